// File: rtl/ccr_pkg.sv
// ============================================================================
// ccr_pkg: shared constants for the control sequence code router
// Table size, buffer size, action and status codes, parse phases and the
// ASCII characters that the prefix parser recognizes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

    // Sizing.
    localparam int TABLE_ENTRIES = 16;
    localparam int BUFFER_BYTES  = 4096;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ISS_W = IDX_W + 1;
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    localparam logic [ISS_W-1:0] NUM_SLOTS = ISS_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(BUFFER_BYTES);

    // Field widths.
    localparam int CODE_W   = 20;
    localparam int KEY_W    = CODE_W + 1;
    localparam int OUT_W    = 13;
    localparam int SLOT_W   = 4;

    localparam logic [23:0] CODE_CLAMP = 24'd1000000;

    // Actions.
    localparam logic [1:0] ACT_REG  = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;
    localparam logic [1:0] ACT_CLR  = 2'd3;

    // Status codes.
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_OVERFLOW = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_DISPATCH = 3'd3;
    localparam logic [2:0] STS_NOCODE   = 3'd4;
    localparam logic [2:0] STS_NOHAND   = 3'd5;

    // Parse phases.
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_NONE   = 2'd3;

    // Characters.
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;

endpackage

`default_nettype wire

// File: rtl/ccr_ram.sv
// ============================================================================
// ccr_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/control_sequence_code_router.sv
// ============================================================================
// control_sequence_code_router: routes a control sequence to a handler slot
// Counts payload bytes, parses the leading code and looks it up in a table
// of registered codes kept in a synchronous RAM.
// ============================================================================
//
// Usage:
//   The input channel (i_valid / o_ready) carries one transaction per item:
//   register a code, a payload byte, an end of sequence, or a buffer clear.
//   The output channel (o_valid / i_ready) returns exactly one result per
//   input transaction, in order, from an output register.
//   Payload bytes, clears and end items without a recognizable code finish
//   without a scan; the result is valid on the cycle after acceptance, and a
//   new item can be accepted every cycle while each result is taken.
//   Register items and end items with a code scan the code table one slot
//   per cycle through the RAM read port, ending early when a matching slot
//   is found. The input is not ready during a scan.
//   Reset clears all slot valid bits, the byte count, the overflow flag and
//   the parse state; no clearing pass is needed since slot contents are only
//   read for valid slots.
//   When the receiver stalls, the result holds in the output register and
//   one more item is not accepted until that result is taken.
//
`timescale 1ns / 1ps
`default_nettype none

module control_sequence_code_router (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [19:0] i_code_value,
    input  wire logic        i_code_is_letter,
    // Output channel.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_handler_slot,
    output logic [19:0]      o_parsed_code,
    output logic             o_parsed_is_letter,
    output logic [12:0]      o_payload_offset,
    output logic [12:0]      o_payload_length,
    output logic             o_overflow_seen
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    logic                              r_state, n_state;
    logic [ccr_pkg::TABLE_ENTRIES-1:0] r_slot_valid, n_slot_valid;
    logic [ccr_pkg::CNT_W-1:0]         r_byte_count, n_byte_count;
    logic                              r_overflow, n_overflow;
    logic [1:0]                        r_phase, n_phase;
    logic [ccr_pkg::CODE_W-1:0]        r_acc, n_acc;
    logic                              r_acc_let, n_acc_let;
    logic [ccr_pkg::CNT_W-1:0]         r_prefix, n_prefix;

    // Scan control.
    logic [ccr_pkg::KEY_W-1:0]         r_key, n_key;
    logic                              r_is_reg, n_is_reg;
    logic [ccr_pkg::ISS_W-1:0]         r_issue, n_issue;
    logic                              r_cmp_vld, n_cmp_vld;
    logic [ccr_pkg::IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic                              r_free_found, n_free_found;
    logic [ccr_pkg::IDX_W-1:0]         r_free_idx, n_free_idx;

    // Output register.
    logic                              r_out_valid, n_out_valid;
    logic [2:0]                        r_status, n_status;
    logic [ccr_pkg::SLOT_W-1:0]        r_slot, n_slot;
    logic [ccr_pkg::CODE_W-1:0]        r_pcode, n_pcode;
    logic                              r_plet, n_plet;
    logic [ccr_pkg::OUT_W-1:0]         r_poff, n_poff;
    logic [ccr_pkg::OUT_W-1:0]         r_plen, n_plen;
    logic                              r_ovf_out, n_ovf_out;

    // RAM interface.
    logic                              w_we;
    logic [ccr_pkg::IDX_W-1:0]         w_waddr;
    logic [ccr_pkg::KEY_W-1:0]         w_rdata;

    // ------------------------------------------------------------------
    // Code table storage.
    // ------------------------------------------------------------------
    ccr_ram #(
        .WIDTH (ccr_pkg::KEY_W),
        .DEPTH (ccr_pkg::TABLE_ENTRIES)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_raddr (r_issue[ccr_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Handshake.
    // ------------------------------------------------------------------
    logic w_accept;

    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Byte classification and decimal accumulation.
    // ------------------------------------------------------------------
    logic        w_is_digit;
    logic        w_is_letter;
    logic [7:0]  w_digit;
    logic [23:0] w_acc_x10;
    logic [23:0] w_acc_clamped;

    assign w_is_digit  = (i_byte_value >= ccr_pkg::CH_0) && (i_byte_value <= ccr_pkg::CH_9);
    assign w_is_letter = ((i_byte_value >= ccr_pkg::CH_UA) && (i_byte_value <= ccr_pkg::CH_UZ)) ||
                         ((i_byte_value >= ccr_pkg::CH_LA) && (i_byte_value <= ccr_pkg::CH_LZ));
    assign w_digit     = i_byte_value - ccr_pkg::CH_0;
    assign w_acc_x10   = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {16'd0, w_digit};
    assign w_acc_clamped = (w_acc_x10 > ccr_pkg::CODE_CLAMP) ? ccr_pkg::CODE_CLAMP : w_acc_x10;

    // ------------------------------------------------------------------
    // Scan compare of the slot read in the previous cycle.
    // ------------------------------------------------------------------
    logic                      w_hit;
    logic                      w_free_now;
    logic                      w_free_any;
    logic [ccr_pkg::IDX_W-1:0] w_free_slot;
    logic                      w_last;

    assign w_hit       = r_cmp_vld && r_slot_valid[r_cmp_idx] && (w_rdata == r_key);
    assign w_free_now  = r_cmp_vld && !r_slot_valid[r_cmp_idx] && !r_free_found;
    assign w_free_any  = r_free_found || w_free_now;
    assign w_free_slot = r_free_found ? r_free_idx : r_cmp_idx;
    assign w_last      = r_cmp_vld && (r_cmp_idx == ccr_pkg::LAST_SLOT);

    // A register miss writes the key into the lowest free slot at scan end.
    assign w_we    = (r_state == S_SCAN) && r_is_reg && !w_hit && w_last && w_free_any;
    assign w_waddr = w_free_slot;

    // Payload length with the prefix removed.
    logic [ccr_pkg::CNT_W-1:0] w_plen;
    assign w_plen = (r_byte_count >= r_prefix) ? (r_byte_count - r_prefix) : '0;

    // ------------------------------------------------------------------
    // Next-state logic.
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_slot_valid = r_slot_valid;
        n_byte_count = r_byte_count;
        n_overflow   = r_overflow;
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_acc_let    = r_acc_let;
        n_prefix     = r_prefix;
        n_key        = r_key;
        n_is_reg     = r_is_reg;
        n_issue      = r_issue;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_out_valid  = r_out_valid && !i_ready;
        n_status     = r_status;
        n_slot       = r_slot;
        n_pcode      = r_pcode;
        n_plet       = r_plet;
        n_poff       = r_poff;
        n_plen       = r_plen;
        n_ovf_out    = r_ovf_out;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Default result fields for items that finish without a scan.
                    n_status = ccr_pkg::STS_OK;
                    n_slot   = '0;
                    n_pcode  = '0;
                    n_plet   = 1'b0;
                    n_poff   = '0;
                    n_plen   = '0;
                    n_issue      = '0;
                    n_free_found = 1'b0;

                    case (i_action)
                        ccr_pkg::ACT_REG: begin
                            n_key    = {i_code_is_letter, i_code_value};
                            n_is_reg = 1'b1;
                            n_state  = S_SCAN;
                        end
                        ccr_pkg::ACT_BYTE: begin
                            n_out_valid = 1'b1;
                            if (r_byte_count >= ccr_pkg::BUF_LIMIT) begin
                                n_overflow = 1'b1;
                                n_status   = ccr_pkg::STS_OVERFLOW;
                            end else begin
                                n_byte_count = r_byte_count + 1'b1;
                                // Prefix parser.
                                case (r_phase)
                                    ccr_pkg::PH_START: begin
                                        if (w_is_digit) begin
                                            n_acc    = ccr_pkg::CODE_W'(w_digit);
                                            n_prefix = ccr_pkg::CNT_W'(1);
                                            n_phase  = ccr_pkg::PH_DIGITS;
                                        end else if (w_is_letter) begin
                                            n_acc     = ccr_pkg::CODE_W'(i_byte_value);
                                            n_acc_let = 1'b1;
                                            n_prefix  = ccr_pkg::CNT_W'(1);
                                            n_phase   = ccr_pkg::PH_DONE;
                                        end else begin
                                            n_phase = ccr_pkg::PH_NONE;
                                        end
                                    end
                                    ccr_pkg::PH_DIGITS: begin
                                        if (w_is_digit) begin
                                            n_acc    = w_acc_clamped[ccr_pkg::CODE_W-1:0];
                                            n_prefix = r_prefix + 1'b1;
                                        end else begin
                                            if (i_byte_value == ccr_pkg::CH_SEMI) begin
                                                n_prefix = r_prefix + 1'b1;
                                            end
                                            n_phase = ccr_pkg::PH_DONE;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            n_ovf_out = n_overflow;
                        end
                        ccr_pkg::ACT_END: begin
                            if (r_phase == ccr_pkg::PH_START || r_phase == ccr_pkg::PH_NONE) begin
                                n_out_valid = 1'b1;
                                n_status    = ccr_pkg::STS_NOCODE;
                                n_ovf_out   = r_overflow;
                            end else begin
                                n_key    = {r_acc_let, r_acc};
                                n_is_reg = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            // Clear: the table is kept.
                            n_out_valid  = 1'b1;
                            n_byte_count = '0;
                            n_overflow   = 1'b0;
                            n_phase      = ccr_pkg::PH_START;
                            n_acc        = '0;
                            n_acc_let    = 1'b0;
                            n_prefix     = '0;
                            n_ovf_out    = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                // Issue the next slot read.
                if (r_issue < ccr_pkg::NUM_SLOTS) begin
                    n_issue   = r_issue + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_issue[ccr_pkg::IDX_W-1:0];
                end
                if (w_free_now) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end

                if (w_hit || w_last) begin
                    n_state     = S_IDLE;
                    n_cmp_vld   = 1'b0;
                    n_out_valid = 1'b1;
                    n_ovf_out   = r_overflow;
                    n_slot      = '0;
                    n_pcode     = '0;
                    n_plet      = 1'b0;
                    n_poff      = '0;
                    n_plen      = '0;
                    if (r_is_reg) begin
                        if (w_hit) begin
                            n_status = ccr_pkg::STS_OK;
                            n_slot   = ccr_pkg::SLOT_W'(r_cmp_idx);
                        end else if (w_free_any) begin
                            n_status = ccr_pkg::STS_OK;
                            n_slot   = ccr_pkg::SLOT_W'(w_free_slot);
                            n_slot_valid[w_free_slot] = 1'b1;
                        end else begin
                            n_status = ccr_pkg::STS_FULL;
                        end
                    end else begin
                        n_status = w_hit ? ccr_pkg::STS_DISPATCH : ccr_pkg::STS_NOHAND;
                        if (w_hit) begin
                            n_slot = ccr_pkg::SLOT_W'(r_cmp_idx);
                        end
                        n_pcode = r_acc;
                        n_plet  = r_acc_let;
                        n_poff  = ccr_pkg::OUT_W'(r_prefix);
                        n_plen  = ccr_pkg::OUT_W'(w_plen);
                    end
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers with reset.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_byte_count <= '0;
            r_overflow   <= 1'b0;
            r_phase      <= ccr_pkg::PH_START;
            r_acc        <= '0;
            r_acc_let    <= 1'b0;
            r_prefix     <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_byte_count <= n_byte_count;
            r_overflow   <= n_overflow;
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_acc_let    <= n_acc_let;
            r_prefix     <= n_prefix;
            r_cmp_vld    <= n_cmp_vld;
            r_out_valid  <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Payload and scan registers without reset.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_is_reg     <= n_is_reg;
        r_issue      <= n_issue;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_pcode      <= n_pcode;
        r_plet       <= n_plet;
        r_poff       <= n_poff;
        r_plen       <= n_plen;
        r_ovf_out    <= n_ovf_out;
    end

    // Outputs.
    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_handler_slot     = r_slot;
    assign o_parsed_code      = r_pcode;
    assign o_parsed_is_letter = r_plet;
    assign o_payload_offset   = r_poff;
    assign o_payload_length   = r_plen;
    assign o_overflow_seen    = r_ovf_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A scan only runs while the output register is empty.
    a_scan_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("scan running with a result still pending");

    // Overflow can only be flagged once the buffer is full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_byte_count == ccr_pkg::BUF_LIMIT))
        else $error("overflow flagged with room in the buffer");

    // The parsed prefix never exceeds the bytes counted.
    a_prefix_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix <= r_byte_count)
        else $error("prefix longer than byte count");

    // A parsed code always has a nonzero prefix.
    a_prefix_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ccr_pkg::PH_DIGITS || r_phase == ccr_pkg::PH_DONE) |-> (r_prefix != '0))
        else $error("code phase with empty prefix");

    // A table write marks its slot valid on the next cycle.
    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_slot_valid[$past(w_waddr)])
        else $error("table write without valid bit");

endmodule

`default_nettype wire
